/* sv/rrps_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the round-robin process scheduler
// no dependencies

package rrps_pkg;

    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_IO     = 2'd1;
    localparam logic [1:0] FUNC_EXIT   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [1:0] ST_READY   = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_SLEEP   = 2'd2;
    localparam logic [1:0] ST_DONE    = 2'd3;

    localparam logic KIND_WAKE = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    // quantum after reset, and base quantum after reset
    localparam logic [5:0] QUANTUM_RST = 6'd3;

    typedef struct packed {
        logic       kind;
        logic [3:0] target_proc;
        logic       target_valid;
        logic [5:0] quantum_after;
        logic       ignored;
        logic       last;
    } word_t;

endpackage

/* sv/rrps_out_stage.sv */
`timescale 1ns / 1ps
// output register for result words, holds a word until it is taken
// depends on rrps_pkg

module rrps_out_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  rrps_pkg::word_t word_in,
    input  logic           stall,
    output logic           valid,
    output rrps_pkg::word_t word_out,
    output logic           free
);

    logic            valid_reg;
    logic            valid_next;
    rrps_pkg::word_t word_reg;

    assign free = !valid_reg || !stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_in;
        end
    end

    assign valid    = valid_reg;
    assign word_out = word_reg;

endmodule

/* sv/round_robin_process_scheduler_core.sv */
`timescale 1ns / 1ps
// Round-robin scheduler over NUM_PROCS processes with an I/O sleep list.
// One word is taken at a time; item_stall stays high until its last result word
// has been loaded into the output register. A tick walks the sleep list and
// the wait memory one entry at a time, pops ring entries when no process runs,
// and walks the quantum memory when the run quantum runs out; an exit walks the
// sleep list. Each result word may further wait on result_stall.
// No clearing pass.
// depends on rrps_pkg, rrps_out_stage

module round_robin_process_scheduler_core
#(
    parameter int NUM_PROCS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [5:0] cfg_wr_data,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [1:0] func,
    input  logic [3:0] proc_index,
    input  logic [3:0] io_duration,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       kind,
    output logic [3:0] target_proc,
    output logic       target_valid,
    output logic [5:0] quantum_after,
    output logic       ignored,
    output logic       last
);

    localparam int PW = $clog2(NUM_PROCS);
    localparam int CW = $clog2(NUM_PROCS + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(NUM_PROCS - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(NUM_PROCS);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DEC    = 5'd1;
    localparam logic [4:0] S_SL_RD  = 5'd2;
    localparam logic [4:0] S_SL_EV  = 5'd3;
    localparam logic [4:0] S_WT_RD  = 5'd4;
    localparam logic [4:0] S_WT_EV  = 5'd5;
    localparam logic [4:0] S_RUNCHK = 5'd6;
    localparam logic [4:0] S_RP_RD  = 5'd7;
    localparam logic [4:0] S_RP_EV  = 5'd8;
    localparam logic [4:0] S_Q_RD   = 5'd9;
    localparam logic [4:0] S_Q_EV   = 5'd10;
    localparam logic [4:0] S_AZ_RD  = 5'd11;
    localparam logic [4:0] S_AZ_EV  = 5'd12;
    localparam logic [4:0] S_AZ_WR  = 5'd13;
    localparam logic [4:0] S_REQ    = 5'd14;
    localparam logic [4:0] S_EMIT   = 5'd15;
    localparam logic [4:0] S_EX_RD  = 5'd16;
    localparam logic [4:0] S_EX_EV  = 5'd17;

    // control registers
    logic [4:0]    state_reg, state_next;
    logic [5:0]    bq_reg;
    logic [1:0]    func_reg;
    logic [3:0]    pin_reg;
    logic [3:0]    dur_reg;
    logic [PW-1:0] i_reg, i_next;
    logic [CW-1:0] r_reg, r_next;
    logic [CW-1:0] w_reg, w_next;
    logic [CW-1:0] slc_reg, slc_next;
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] rcnt_reg, rcnt_next;
    logic [PW-1:0] run_reg, run_next;
    logic          runv_reg, runv_next;
    logic [31:0]   tick_reg, tick_next;
    logic          pv_reg, pv_next;
    logic [5:0]    qa_reg, qa_next;
    logic          ign_reg, ign_next;
    logic          any_reg, any_next;

    // per-process flags
    logic [1:0]          st_reg [NUM_PROCS];
    logic [NUM_PROCS-1:0] inr_reg;
    logic [NUM_PROCS-1:0] qv_reg;
    logic [NUM_PROCS-1:0] wv_reg;
    logic [NUM_PROCS-1:0] rv_reg;

    // memories
    logic [PW-1:0] sl_proc_mem [NUM_PROCS];
    logic [31:0]   sl_wake_mem [NUM_PROCS];
    logic [5:0]    q_mem [NUM_PROCS];
    logic [31:0]   wt_mem [NUM_PROCS];
    logic [PW-1:0] ring_mem [NUM_PROCS];

    logic [PW-1:0] sl_proc_rd;
    logic [31:0]   sl_wake_rd;
    logic [5:0]    q_rd;
    logic [31:0]   wt_rd;
    logic [PW-1:0] rg_rd;

    // strobes
    logic          st_we;
    logic [PW-1:0] st_widx;
    logic [1:0]    st_wdata;
    logic [PW-1:0] st_idx;
    logic [1:0]    st_rd;
    logic          sl_we;
    logic [PW-1:0] sl_waddr;
    logic [PW-1:0] sl_wproc;
    logic [31:0]   sl_wwake;
    logic          q_we;
    logic [PW-1:0] q_waddr;
    logic [5:0]    q_wdata;
    logic [PW-1:0] q_raddr;
    logic          wt_we;
    logic          push_en;
    logic [PW-1:0] push_idx;
    logic          push_ok;
    logic          pop_clr;
    logic          out_load;
    logic          out_free;
    rrps_pkg::word_t out_word;
    rrps_pkg::word_t out_q;

    logic          pok;
    logic [PW-1:0] pidx;
    logic          due;
    logic [31:0]   diff;
    logic [5:0]    qn;
    logic [CW-1:0] r_inc;
    logic [CW-1:0] w_inc;
    logic [PW-1:0] head_inc;
    logic [PW-1:0] tail_inc;

    assign pok      = ({2'b00, pin_reg} < 6'(NUM_PROCS));
    assign pidx     = PW'(pin_reg);
    assign diff     = tick_reg - sl_wake_rd;
    assign due      = !diff[31];
    assign qn       = (q_rd != 6'd0) ? (q_rd - 6'd1) : 6'd0;
    assign r_inc    = r_reg + 1'b1;
    assign w_inc    = w_reg + 1'b1;
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign st_rd    = (32'(st_idx) < NUM_PROCS) ? st_reg[st_idx] : rrps_pkg::ST_READY;
    assign push_idx = (state_reg == S_SL_EV) ? sl_proc_rd : run_reg;
    assign push_ok  = !inr_reg[push_idx] && (rcnt_reg < FULL_CNT);
    assign q_raddr  = (state_reg == S_Q_RD) ? run_reg : i_reg;
    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        case (state_reg)
            S_DEC:   st_idx = pidx;
            S_SL_EV: st_idx = sl_proc_rd;
            S_WT_EV: st_idx = i_reg;
            S_RP_EV: st_idx = rg_rd;
            S_AZ_EV: st_idx = i_reg;
            S_AZ_WR: st_idx = i_reg;
            default: st_idx = run_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        r_next     = r_reg;
        w_next     = w_reg;
        slc_next   = slc_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        rcnt_next  = rcnt_reg;
        run_next   = run_reg;
        runv_next  = runv_reg;
        tick_next  = tick_reg;
        pv_next    = pv_reg;
        qa_next    = qa_reg;
        ign_next   = ign_reg;
        any_next   = any_reg;
        st_we      = 1'b0;
        st_widx    = st_idx;
        st_wdata   = rrps_pkg::ST_READY;
        sl_we      = 1'b0;
        sl_waddr   = w_reg[PW-1:0];
        sl_wproc   = sl_proc_rd;
        sl_wwake   = sl_wake_rd;
        q_we       = 1'b0;
        q_waddr    = run_reg;
        q_wdata    = bq_reg;
        wt_we      = 1'b0;
        push_en    = 1'b0;
        pop_clr    = 1'b0;
        out_load   = 1'b0;
        out_word   = '{kind: rrps_pkg::KIND_STEP, target_proc: pv_reg ? 4'(run_reg) : 4'd0,
                       target_valid: pv_reg, quantum_after: qa_reg,
                       ignored: ign_reg, last: 1'b1};

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                pv_next  = 1'b0;
                qa_next  = 6'd0;
                ign_next = 1'b1;
                r_next   = '0;
                w_next   = '0;
                state_next = S_EMIT;
                case (func_reg)
                    rrps_pkg::FUNC_TICK:
                    begin
                        ign_next  = 1'b0;
                        tick_next = tick_reg + 32'd1;
                        i_next    = '0;
                        state_next = (slc_reg == '0) ? S_WT_RD : S_SL_RD;
                    end
                    rrps_pkg::FUNC_IO:
                    begin
                        if (pok && st_rd != rrps_pkg::ST_SLEEP && st_rd != rrps_pkg::ST_DONE
                            && slc_reg < FULL_CNT)
                        begin
                            sl_we    = 1'b1;
                            sl_waddr = slc_reg[PW-1:0];
                            sl_wproc = pidx;
                            sl_wwake = tick_reg + 32'(dur_reg);
                            slc_next = slc_reg + 1'b1;
                            st_we    = 1'b1;
                            st_widx  = pidx;
                            st_wdata = rrps_pkg::ST_SLEEP;
                            if (runv_reg && run_reg == pidx)
                            begin
                                runv_next = 1'b0;
                            end
                            ign_next = 1'b0;
                        end
                    end
                    rrps_pkg::FUNC_EXIT:
                    begin
                        if (pok && st_rd != rrps_pkg::ST_DONE)
                        begin
                            st_we    = 1'b1;
                            st_widx  = pidx;
                            st_wdata = rrps_pkg::ST_DONE;
                            if (runv_reg && run_reg == pidx)
                            begin
                                runv_next = 1'b0;
                            end
                            ign_next = 1'b0;
                            state_next = (slc_reg == '0) ? S_EMIT : S_EX_RD;
                        end
                    end
                    default:
                    begin
                        ign_next = 1'b1;
                    end
                endcase
            end
            S_SL_RD:
            begin
                state_next = S_SL_EV;
            end
            S_SL_EV:
            begin
                if (!due || out_free)
                begin
                    if (due)
                    begin
                        q_we     = 1'b1;
                        q_waddr  = sl_proc_rd;
                        st_we    = 1'b1;
                        st_widx  = sl_proc_rd;
                        st_wdata = rrps_pkg::ST_READY;
                        push_en  = push_ok;
                        out_load = 1'b1;
                        out_word = '{kind: rrps_pkg::KIND_WAKE, target_proc: 4'(sl_proc_rd),
                                     target_valid: 1'b1, quantum_after: 6'd0,
                                     ignored: 1'b0, last: 1'b0};
                    end
                    else
                    begin
                        sl_we  = 1'b1;
                        w_next = w_inc;
                    end
                    r_next = r_inc;
                    if (r_inc == slc_reg)
                    begin
                        slc_next   = due ? w_reg : w_inc;
                        i_next     = '0;
                        state_next = S_WT_RD;
                    end
                    else
                    begin
                        state_next = S_SL_RD;
                    end
                end
            end
            S_WT_RD:
            begin
                state_next = S_WT_EV;
            end
            S_WT_EV:
            begin
                wt_we = (st_rd == rrps_pkg::ST_READY);
                if (i_reg == LAST_IDX)
                begin
                    state_next = S_RUNCHK;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_WT_RD;
                end
            end
            S_RUNCHK:
            begin
                if (runv_reg && st_rd != rrps_pkg::ST_DONE && st_rd != rrps_pkg::ST_SLEEP)
                begin
                    state_next = (st_rd == rrps_pkg::ST_RUNNING) ? S_Q_RD : S_EMIT;
                end
                else
                begin
                    runv_next  = 1'b0;
                    state_next = (rcnt_reg != '0) ? S_RP_RD : S_EMIT;
                end
            end
            S_RP_RD:
            begin
                state_next = S_RP_EV;
            end
            S_RP_EV:
            begin
                head_next = head_inc;
                rcnt_next = rcnt_reg - 1'b1;
                pop_clr   = 1'b1;
                if (st_rd == rrps_pkg::ST_READY)
                begin
                    run_next   = rg_rd;
                    runv_next  = 1'b1;
                    st_we      = 1'b1;
                    st_widx    = rg_rd;
                    st_wdata   = rrps_pkg::ST_RUNNING;
                    q_we       = 1'b1;
                    q_waddr    = rg_rd;
                    state_next = S_Q_RD;
                end
                else
                begin
                    state_next = (rcnt_reg != CW'(1)) ? S_RP_RD : S_EMIT;
                end
            end
            S_Q_RD:
            begin
                state_next = S_Q_EV;
            end
            S_Q_EV:
            begin
                q_we    = 1'b1;
                q_wdata = qn;
                pv_next = 1'b1;
                qa_next = qn;
                if (qn == 6'd0)
                begin
                    i_next     = '0;
                    any_next   = 1'b0;
                    state_next = S_AZ_RD;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_AZ_RD:
            begin
                state_next = S_AZ_EV;
            end
            S_AZ_EV:
            begin
                if (st_rd == rrps_pkg::ST_READY && q_rd != 6'd0)
                begin
                    any_next = 1'b1;
                end
                if (i_reg == LAST_IDX)
                begin
                    i_next     = '0;
                    state_next = (any_next) ? S_REQ : S_AZ_WR;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_AZ_RD;
                end
            end
            S_AZ_WR:
            begin
                // every ready quantum spent: refill them all
                q_we    = (st_rd == rrps_pkg::ST_READY);
                q_waddr = i_reg;
                if (i_reg == LAST_IDX)
                begin
                    state_next = S_REQ;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_REQ:
            begin
                st_we      = 1'b1;
                st_widx    = run_reg;
                st_wdata   = rrps_pkg::ST_READY;
                push_en    = push_ok;
                runv_next  = 1'b0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EX_RD:
            begin
                state_next = S_EX_EV;
            end
            S_EX_EV:
            begin
                if (sl_proc_rd != pidx)
                begin
                    sl_we  = 1'b1;
                    w_next = w_inc;
                end
                r_next = r_inc;
                if (r_inc == slc_reg)
                begin
                    slc_next   = w_next;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_EX_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (push_en)
        begin
            tail_next = tail_inc;
            rcnt_next = rcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bq_reg    <= rrps_pkg::QUANTUM_RST;
            i_reg     <= '0;
            r_reg     <= '0;
            w_reg     <= '0;
            slc_reg   <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            rcnt_reg  <= FULL_CNT;
            run_reg   <= '0;
            runv_reg  <= 1'b0;
            tick_reg  <= '0;
            pv_reg    <= 1'b0;
            qa_reg    <= '0;
            ign_reg   <= 1'b0;
            any_reg   <= 1'b0;
            inr_reg   <= '1;
            qv_reg    <= '0;
            wv_reg    <= '0;
            rv_reg    <= '0;
            for (int k = 0; k < NUM_PROCS; k++)
            begin
                st_reg[k] <= rrps_pkg::ST_READY;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                bq_reg <= cfg_wr_data;
            end
            i_reg    <= i_next;
            r_reg    <= r_next;
            w_reg    <= w_next;
            slc_reg  <= slc_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            rcnt_reg <= rcnt_next;
            run_reg  <= run_next;
            runv_reg <= runv_next;
            tick_reg <= tick_next;
            pv_reg   <= pv_next;
            qa_reg   <= qa_next;
            ign_reg  <= ign_next;
            any_reg  <= any_next;
            if (st_we)
            begin
                st_reg[st_widx] <= st_wdata;
            end
            if (q_we)
            begin
                qv_reg[q_waddr] <= 1'b1;
            end
            if (wt_we)
            begin
                wv_reg[i_reg] <= 1'b1;
            end
            if (pop_clr)
            begin
                inr_reg[rg_rd] <= 1'b0;
            end
            if (push_en)
            begin
                inr_reg[push_idx] <= 1'b1;
                rv_reg[tail_reg]  <= 1'b1;
            end
        end
    end

    // captured item
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && item_valid)
        begin
            func_reg <= func;
            pin_reg  <= proc_index;
            dur_reg  <= io_duration;
        end
    end

    // sleep list
    always_ff @(posedge clk)
    begin
        if (sl_we)
        begin
            sl_proc_mem[sl_waddr] <= sl_wproc;
            sl_wake_mem[sl_waddr] <= sl_wwake;
        end
        sl_proc_rd <= sl_proc_mem[r_reg[PW-1:0]];
        sl_wake_rd <= sl_wake_mem[r_reg[PW-1:0]];
    end

    // quantum table, unwritten entries read as the reset quantum
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[q_waddr] <= q_wdata;
        end
        q_rd <= qv_reg[q_raddr] ? q_mem[q_raddr] : rrps_pkg::QUANTUM_RST;
    end

    // accumulated ready wait
    always_ff @(posedge clk)
    begin
        if (wt_we)
        begin
            wt_mem[i_reg] <= wt_rd + 32'd1;
        end
        wt_rd <= wv_reg[i_reg] ? wt_mem[i_reg] : 32'd0;
    end

    // ready ring, unwritten entry i holds i
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            ring_mem[tail_reg] <= push_idx;
        end
        rg_rd <= rv_reg[head_reg] ? ring_mem[head_reg] : head_reg;
    end

    rrps_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_load),
        .word_in  (out_word),
        .stall    (result_stall),
        .valid    (result_valid),
        .word_out (out_q),
        .free     (out_free)
    );

    assign kind          = out_q.kind;
    assign target_proc   = out_q.target_proc;
    assign target_valid  = out_q.target_valid;
    assign quantum_after = out_q.quantum_after;
    assign ignored       = out_q.ignored;
    assign last          = out_q.last;

    a_ring_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        rcnt_reg <= FULL_CNT)
        else $error("ring count above capacity");

    a_sleep_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        slc_reg <= FULL_CNT)
        else $error("sleep list above capacity");

    a_run_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && runv_reg) |-> st_reg[run_reg] == rrps_pkg::ST_RUNNING)
        else $error("running process not in running state");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result word loaded over a pending word");

endmodule

/* bench/round_robin_process_scheduler_core_tb.sv */
`timescale 1ns / 1ps
// testbench for round_robin_process_scheduler_core: random and directed ticks, io requests
// and exits, result words checked against a built-in scheduler model by a small scoreboard
// depends on rrps_pkg and the core

module round_robin_process_scheduler_core_tb;

    localparam int NP = 16;

    class sched_scoreboard;
        logic [5:0]  base_q;
        logic [1:0]  status [NP];
        logic [5:0]  quantum [NP];
        logic [31:0] wait_cnt [NP];
        logic [3:0]  ring [NP];
        int          head, tail, count;
        logic [3:0]  slp_proc [NP];
        logic [31:0] slp_wake [NP];
        int          slp_count;
        logic [3:0]  run_proc;
        bit          run_valid;
        logic [31:0] now;
        rrps_pkg::word_t pending [$];
        int          errors;
        int          words_seen;
        int          wakes_seen;

        function void reset_state();
            base_q = rrps_pkg::QUANTUM_RST;
            for (int i = 0; i < NP; i++)
            begin
                status[i] = rrps_pkg::ST_READY;
                quantum[i] = rrps_pkg::QUANTUM_RST;
                wait_cnt[i] = 0;
                ring[i] = i[3:0];
                slp_proc[i] = 0;
                slp_wake[i] = 0;
            end
            head = 0;
            tail = 0;
            count = NP;
            slp_count = 0;
            run_proc = 0;
            run_valid = 0;
            now = 0;
            errors = 0;
            words_seen = 0;
            wakes_seen = 0;
        endfunction

        function void push_word(logic k, logic [3:0] p, logic v, logic [5:0] q,
                                logic ign, logic lst);
            rrps_pkg::word_t w;
            w.kind = k;
            w.target_proc = p;
            w.target_valid = v;
            w.quantum_after = q;
            w.ignored = ign;
            w.last = lst;
            pending.push_back(w);
        endfunction

        function void ring_add(logic [3:0] p);
            if (count >= NP || status[p] != rrps_pkg::ST_READY)
                return;
            for (int i = 0; i < count; i++)
                if (ring[(head + i) % NP] == p)
                    return;
            ring[tail] = p;
            tail = (tail + 1) % NP;
            count++;
        endfunction

        function bit ring_take(output logic [3:0] p);
            int n;
            logic [3:0] e;
            n = count;
            p = 0;
            while (n > 0)
            begin
                n--;
                e = ring[head];
                head = (head + 1) % NP;
                count--;
                if (status[e] == rrps_pkg::ST_READY)
                begin
                    p = e;
                    return 1;
                end
            end
            return 0;
        endfunction

        function void sleeper_drop(int idx);
            for (int j = idx; j + 1 < slp_count; j++)
            begin
                slp_proc[j] = slp_proc[j + 1];
                slp_wake[j] = slp_wake[j + 1];
            end
            if (slp_count > 0)
                slp_count--;
        endfunction

        function void tick();
            int i;
            logic [3:0] p;
            logic [31:0] d;
            logic [3:0] pulsed;
            logic [5:0] qa;
            bit pv, spent_all;
            pulsed = 0;
            qa = 0;
            pv = 0;
            now++;
            i = 0;
            while (i < slp_count)
            begin
                d = now - slp_wake[i];
                if (!d[31])
                begin
                    p = slp_proc[i];
                    sleeper_drop(i);
                    quantum[p] = base_q;
                    status[p] = rrps_pkg::ST_READY;
                    ring_add(p);
                    push_word(rrps_pkg::KIND_WAKE, p, 1'b1, 6'd0, 1'b0, 1'b0);
                end
                else
                    i++;
            end
            for (i = 0; i < NP; i++)
                if (status[i] == rrps_pkg::ST_READY)
                    wait_cnt[i]++;
            if (run_valid && (status[run_proc] == rrps_pkg::ST_DONE
                              || status[run_proc] == rrps_pkg::ST_SLEEP))
                run_valid = 0;
            if (!run_valid && ring_take(p))
            begin
                run_proc = p;
                run_valid = 1;
                status[p] = rrps_pkg::ST_RUNNING;
                quantum[p] = base_q;
            end
            if (run_valid && status[run_proc] == rrps_pkg::ST_RUNNING)
            begin
                p = run_proc;
                if (quantum[p] > 0)
                    quantum[p]--;
                pulsed = p;
                pv = 1;
                qa = quantum[p];
                if (quantum[p] == 0)
                begin
                    spent_all = 1;
                    for (i = 0; i < NP; i++)
                        if (status[i] == rrps_pkg::ST_READY && quantum[i] > 0)
                            spent_all = 0;
                    if (spent_all)
                        for (i = 0; i < NP; i++)
                            if (status[i] == rrps_pkg::ST_READY)
                                quantum[i] = base_q;
                    status[p] = rrps_pkg::ST_READY;
                    ring_add(p);
                    run_valid = 0;
                end
            end
            push_word(rrps_pkg::KIND_STEP, pulsed, pv, qa, 1'b0, 1'b1);
        endfunction

        function void note_item(logic [1:0] f, logic [3:0] p, logic [3:0] dur);
            int i;
            logic ign;
            ign = 1;
            if (f == rrps_pkg::FUNC_TICK)
            begin
                tick();
                return;
            end
            if (f == rrps_pkg::FUNC_IO)
            begin
                if (status[p] != rrps_pkg::ST_SLEEP && status[p] != rrps_pkg::ST_DONE
                    && slp_count < NP)
                begin
                    slp_proc[slp_count] = p;
                    slp_wake[slp_count] = now + dur;
                    slp_count++;
                    status[p] = rrps_pkg::ST_SLEEP;
                    if (run_valid && run_proc == p)
                        run_valid = 0;
                    ign = 0;
                end
            end
            else if (f == rrps_pkg::FUNC_EXIT)
            begin
                if (status[p] != rrps_pkg::ST_DONE)
                begin
                    status[p] = rrps_pkg::ST_DONE;
                    if (run_valid && run_proc == p)
                        run_valid = 0;
                    i = 0;
                    while (i < slp_count)
                    begin
                        if (slp_proc[i] == p)
                            sleeper_drop(i);
                        else
                            i++;
                    end
                    ign = 0;
                end
            end
            push_word(rrps_pkg::KIND_STEP, 4'd0, 1'b0, 6'd0, ign, 1'b1);
        endfunction

        function void check_word(rrps_pkg::word_t got);
            rrps_pkg::word_t w;
            words_seen++;
            if (pending.size() == 0)
            begin
                $error("unexpected result word %p", got);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (w.kind == rrps_pkg::KIND_WAKE)
                wakes_seen++;
            if (got.kind !== w.kind)
            begin
                $error("kind: expected %0d got %0d", w.kind, got.kind);
                errors++;
            end
            if (got.target_proc !== w.target_proc)
            begin
                $error("target_proc: expected %0d got %0d", w.target_proc, got.target_proc);
                errors++;
            end
            if (got.target_valid !== w.target_valid)
            begin
                $error("target_valid: expected %0d got %0d", w.target_valid,
                       got.target_valid);
                errors++;
            end
            if (got.quantum_after !== w.quantum_after)
            begin
                $error("quantum_after: expected %0d got %0d", w.quantum_after,
                       got.quantum_after);
                errors++;
            end
            if (got.ignored !== w.ignored)
            begin
                $error("ignored: expected %0d got %0d", w.ignored, got.ignored);
                errors++;
            end
            if (got.last !== w.last)
            begin
                $error("last: expected %0d got %0d", w.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [5:0] cfg_wr_data;
    logic       item_valid;
    logic       item_stall;
    logic [1:0] func;
    logic [3:0] proc_index;
    logic [3:0] io_duration;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic       kind;
    logic [3:0] target_proc;
    logic       target_valid;
    logic [5:0] quantum_after;
    logic       ignored;
    logic       last;

    sched_scoreboard sb;
    int items_sent;
    bit rx_hold;
    int rx_wait = 0;

    round_robin_process_scheduler_core #(.NUM_PROCS(NP)) uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .item_valid(item_valid), .item_stall(item_stall),
        .func(func), .proc_index(proc_index), .io_duration(io_duration),
        .result_valid(result_valid), .result_stall(result_stall),
        .kind(kind), .target_proc(target_proc), .target_valid(target_valid),
        .quantum_after(quantum_after), .ignored(ignored), .last(last)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    // result side: check at the rising edge, then draw the wait before the next word
    always @(posedge clk)
    begin
        rrps_pkg::word_t w;
        if (rst_n && result_valid && !result_stall)
        begin
            w.kind = kind;
            w.target_proc = target_proc;
            w.target_valid = target_valid;
            w.quantum_after = quantum_after;
            w.ignored = ignored;
            w.last = last;
            sb.check_word(w);
            rx_wait = rx_hold ? 0 : $urandom_range(0, 3);
        end
    end

    always @(negedge clk)
    begin
        if (rx_wait > 0)
        begin
            result_stall <= 1'b1;
            rx_wait = rx_wait - 1;
        end
        else
            result_stall <= 1'b0;
    end

    task automatic send_word(logic [1:0] f, logic [3:0] p, logic [3:0] dur, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 3) : 0;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        func <= f;
        proc_index <= p;
        io_duration <= dur;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_item(f, p, dur);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_quantum(logic [5:0] q);
        // drain the result words, then let the core idle before the write
        item_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (120) @(negedge clk);
        cfg_wr_data <= q;
        cfg_wr_en <= 1'b1;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.base_q = q;
    endtask

    task automatic random_phase(int n, bit gaps);
        int r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                send_word(rrps_pkg::FUNC_TICK, 4'($urandom), 4'($urandom), gaps);
            else if (r < 85)
                send_word(rrps_pkg::FUNC_IO, 4'($urandom), 4'($urandom), gaps);
            else if (r < 97)
                send_word(rrps_pkg::FUNC_EXIT, 4'($urandom), 4'($urandom), gaps);
            else
                send_word(rrps_pkg::FUNC_UNUSED, 4'($urandom), 4'($urandom), gaps);
        end
    endtask

    initial
    begin
        #5000000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        sb = new();
        sb.reset_state();
        items_sent = 0;
        rx_hold = 0;
        rst_n = 0;
        cfg_wr_en = 0;
        cfg_wr_data = 0;
        item_valid = 0;
        func = 0;
        proc_index = 0;
        io_duration = 0;
        repeat (8) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: ticks, zero and maximum duration, exits, unused code, repeats
        send_word(rrps_pkg::FUNC_TICK, 4'd0, 4'd0, 0);
        send_word(rrps_pkg::FUNC_IO, 4'd0, 4'd0, 0);
        send_word(rrps_pkg::FUNC_IO, 4'd15, 4'd15, 0);
        send_word(rrps_pkg::FUNC_IO, 4'd15, 4'd3, 0);
        send_word(rrps_pkg::FUNC_TICK, 4'd0, 4'd0, 0);
        send_word(rrps_pkg::FUNC_EXIT, 4'd15, 4'd0, 0);
        send_word(rrps_pkg::FUNC_EXIT, 4'd15, 4'd0, 0);
        send_word(rrps_pkg::FUNC_IO, 4'd15, 4'd1, 0);
        send_word(rrps_pkg::FUNC_UNUSED, 4'd15, 4'd15, 0);
        send_word(rrps_pkg::FUNC_IO, 4'd1, 4'd1, 0);
        for (int k = 0; k < 6; k++)
            send_word(rrps_pkg::FUNC_TICK, 4'd0, 4'd0, 0);
        send_word(rrps_pkg::FUNC_EXIT, 4'd2, 4'd0, 0);
        for (int k = 0; k < 4; k++)
            send_word(rrps_pkg::FUNC_TICK, 4'd5, 4'd10, 0);

        write_quantum(6'd0);
        random_phase(40, 1);
        write_quantum(6'd63);
        random_phase(60, 1);
        write_quantum(6'd1);
        rx_hold = 1;
        random_phase(50, 0);
        rx_hold = 0;
        write_quantum(6'($urandom_range(2, 62)));
        random_phase(140, 1);

        item_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        $display("covered %0d items, %0d result words (%0d wake notices)",
                 items_sent, sb.words_seen, sb.wakes_seen);
        $display("base quantum swept 3, 0, 63, 1 and a random value");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
sv/rrps_pkg.sv
sv/rrps_out_stage.sv
sv/round_robin_process_scheduler_core.sv
bench/round_robin_process_scheduler_core_tb.sv
